@@ design/tbd_pkg.sv @@
// ---------------------------------------------------------------------------
// tbd_pkg: shared types and constants for the text box decoder
// Word layouts for the input and result channels, the angle table and
// register indexes.
// ---------------------------------------------------------------------------
package tbd_pkg;

  typedef struct packed {
    logic [15:0]        cell_score;
    logic signed [15:0] dist_top;
    logic signed [15:0] dist_right;
    logic signed [15:0] dist_bottom;
    logic signed [15:0] dist_left;
    logic signed [15:0] rotation;
    logic [8:0]         cell_col;
    logic [8:0]         cell_row;
    logic               frame_end;
  } in_word_t;

  typedef struct packed {
    logic [15:0] box_top;
    logic [15:0] box_left;
    logic [15:0] box_bottom;
    logic [15:0] box_right;
    logic [15:0] box_score;
    logic        box_valid;
    logic        list_overflow;
    logic        last_box;
  } out_word_t;

  // register indexes
  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_RX     = 3'd1;
  localparam logic [2:0] REG_RY     = 3'd2;
  localparam logic [2:0] REG_RW     = 3'd3;
  localparam logic [2:0] REG_RH     = 3'd4;

  // quarter-wave sine, Q1.14, 16 segments
  function automatic logic [14:0] sine_pt(input logic [4:0] i);
    case (i)
      5'd0: sine_pt = 15'd0;
      5'd1: sine_pt = 15'd1606;
      5'd2: sine_pt = 15'd3196;
      5'd3: sine_pt = 15'd4756;
      5'd4: sine_pt = 15'd6270;
      5'd5: sine_pt = 15'd7723;
      5'd6: sine_pt = 15'd9102;
      5'd7: sine_pt = 15'd10394;
      5'd8: sine_pt = 15'd11585;
      5'd9: sine_pt = 15'd12665;
      5'd10: sine_pt = 15'd13623;
      5'd11: sine_pt = 15'd14449;
      5'd12: sine_pt = 15'd15137;
      5'd13: sine_pt = 15'd15679;
      5'd14: sine_pt = 15'd16069;
      5'd15: sine_pt = 15'd16305;
      default: sine_pt = 15'd16384;
    endcase
  endfunction

  // interpolated sine for phase 0..4096 (4096 = pi/2)
  function automatic logic [14:0] qsine(input logic [12:0] p);
    logic [4:0]  i;
    logic [7:0]  f;
    logic [14:0] a, b;
    logic [22:0] d;
    i = {1'b0, p[11:8]};
    f = p[7:0];
    a = sine_pt(i);
    b = sine_pt(i + 5'd1);
    d = 23'(b - a) * 23'(f);
    if (p[12]) qsine = 15'd16384;
    else qsine = a + 15'(d >> 8);
  endfunction

endpackage

@@ design/tbd_ram.sv @@
// ---------------------------------------------------------------------------
// tbd_ram: generic single-port-write, single-read RAM
// Registered read.
// ---------------------------------------------------------------------------
module tbd_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ design/tbd_divider.sv @@
// ---------------------------------------------------------------------------
// tbd_divider: restoring divider for box normalization
// Positive numerator over 4*size, quotient saturated to 16 bits, 1 bit/cycle.
// ---------------------------------------------------------------------------
module tbd_divider
  import tbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [47:0] num,
  input  logic [12:0] size,
  output logic        running,
  output logic        done,
  output logic [15:0] quo
);
  logic [47:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic [14:0] dv_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        big_r, big_nxt;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    big_nxt = big_r;
    if (go) begin
      rem_nxt = num;
      q_nxt   = '0;
      cnt_nxt = 5'd16;
      run_nxt = 1'b1;
      big_nxt = 1'b0;
    end else if (run_r) begin
      if ({16'd0, rem_r} >= ({49'd0, dv_r} << cnt_r)) begin
        rem_nxt = rem_r - 48'({49'd0, dv_r} << cnt_r);
        q_nxt   = q_r | (17'd1 << cnt_r);
      end
      if (cnt_r == 5'd0) run_nxt = 1'b0;
      else cnt_nxt = cnt_r - 5'd1;
    end
    if (run_r && ({16'd0, rem_r} >= ({49'd0, dv_r} << 17))) big_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    big_r <= big_nxt;
    if (go) dv_r <= {(size == 13'd0) ? 13'd1 : size, 2'b00};
  end

  assign running = run_r;
  assign done = run_r && !run_nxt;
  assign quo  = (big_nxt || q_nxt[16]) ? 16'hFFFF : q_nxt[15:0];
endmodule

@@ design/text_box_decode_nms_core.sv @@
// ---------------------------------------------------------------------------
// text_box_decode_nms_core: rotated text box decode with greedy NMS
//
//   channel | ports                     | handshake
//   input   | start/in_data/busy        | taken when start && !busy
//   result  | out_strobe/out_data       | one strobe per word, no stall
//   config  | cfg_we/cfg_index/cfg_data | written on cfg_we
//
// Cells under threshold are dropped. Surviving cells: TRIG, MUL and SUM
// decode, the shared divider runs per coordinate, then each kept entry is
// read (registered RAM read) and checked; the box is appended, dropped, or
// on a replace the entries after the hit move up in the close-up shift and
// the new box is written last. frame_end: EMITR then EMIT per word. Reset
// clears count and overflow; list RAM needs no clearing. Results can't stall.
// ---------------------------------------------------------------------------
module text_box_decode_nms_core
  import tbd_pkg::*;
#(
  parameter int MAX_BOXES = 32,
  parameter int GRID_MAX  = 480
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_strobe,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_TRIG  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_SUM   = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_SCAN  = 10'b0000100000,
    S_CHK   = 10'b0001000000,
    S_SHIFT = 10'b0010000000,
    S_EMITR = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t      st_r, st_nxt;
  logic [15:0] thr_r, rx_r, ry_r, rw_r, rh_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  in_word_t    cell_r;
  logic signed [15:0] s_r, c_r;
  logic signed [47:0] m_r [4];
  logic signed [47:0] rr_r, bb_r, ll_r, tt_r;
  logic [1:0]  dk_r, dk_nxt;
  logic [63:0] box_r, box_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hit_r, hit_nxt;
  logic        fe_r;

  // ---- config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd45875; rx_r <= '0; ry_r <= '0;
      rw_r <= 16'd1920; rh_r <= 16'd1920;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESH: thr_r <= cfg_data;
        REG_RX: rx_r <= {4'd0, cfg_data[11:0]};
        REG_RY: ry_r <= {4'd0, cfg_data[11:0]};
        REG_RW: rw_r <= {3'd0, cfg_data[12:0]};
        REG_RH: rh_r <= {3'd0, cfg_data[12:0]};
        default: ;
      endcase
    end
  end

  // ---- angle lookup from the captured cell
  logic [15:0] mag;
  logic [31:0] pm;
  logic [12:0] ph;
  logic [14:0] sv, cv;
  always_comb begin
    mag = cell_r.rotation[15] ? 16'(-cell_r.rotation) : cell_r.rotation;
    pm  = 32'(mag) * 32'd10430;
    ph  = (pm[31:16] > 16'd4096) ? 13'd4096 : pm[28:16];
    sv  = qsine(ph);
    cv  = qsine(13'd4096 - ph);
  end

  // ---- divider, shared over the four coordinates
  logic        dgo, ddone, drun;
  logic [47:0] dnum;
  logic [12:0] dsize;
  logic [15:0] dquo;
  logic signed [47:0] dsel;
  logic signed [47:0] dorg;
  always_comb begin
    case (dk_r)
      2'd0: begin dsel = tt_r; dorg = 48'(ry_r) <<< 18; end
      2'd1: begin dsel = ll_r; dorg = 48'(rx_r) <<< 18; end
      2'd2: begin dsel = bb_r; dorg = 48'(ry_r) <<< 18; end
      default: begin dsel = rr_r; dorg = 48'(rx_r) <<< 18; end
    endcase
    dnum  = 48'(dsel - dorg);
    dsize = dk_r[0] ? rw_r[12:0] : rh_r[12:0];
  end
  logic dpos;
  assign dpos = !dnum[47] && (dnum != 48'd0);

  tbd_divider u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .size(dsize),
    .running(drun), .done(ddone), .quo(dquo)
  );

  // ---- list RAM: {score, right, bottom, left, top}
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [79:0]   wdata, rdata;
  tbd_ram #(.WIDTH(80), .DEPTH(2 ** AW)) u_list (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // ---- overlap test of the new box against the entry just read
  logic [16:0] at, al, ab, ar, bt, bl, bb, br;
  logic signed [17:0] ow, oh;
  logic [33:0] inter, ua, ub;
  logic        ovl;
  always_comb begin
    at = {1'b0, box_r[15:0]};  al = {1'b0, box_r[31:16]};
    ab = {1'b0, box_r[47:32]}; ar = {1'b0, box_r[63:48]};
    bt = {1'b0, rdata[15:0]};  bl = {1'b0, rdata[31:16]};
    bb = {1'b0, rdata[47:32]}; br = {1'b0, rdata[63:48]};
    ow = 18'((ar < br) ? ar : br) - 18'((al > bl) ? al : bl);
    oh = 18'((ab < bb) ? ab : bb) - 18'((at > bt) ? at : bt);
    inter = 34'(ow[16:0]) * 34'(oh[16:0]);
    ua = 34'(ar - al) * 34'(ab - at);
    ub = 34'(br - bl) * 34'(bb - bt);
    ovl = (ow > 0) && (oh > 0) &&
          ({inter, 1'b0} + {1'b0, inter} > {1'b0, ua} + {1'b0, ub});
  end

  // ---- sequencer
  logic    accept;
  assign accept = start && !busy;
  assign busy = (st_r != S_IDLE);

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    dk_nxt  = dk_r;
    box_nxt = box_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    dgo = 1'b0;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = {cell_r.cell_score, box_r};
    raddr = idx_r[AW-1:0];
    out_strobe = 1'b0;
    out_data = '0;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cell_score >= thr_r) st_nxt = S_TRIG;
          else if (in_data.frame_end) begin
            idx_nxt = '0; st_nxt = S_EMITR;
          end
        end
      end
      S_TRIG: st_nxt = S_MUL;
      S_MUL: st_nxt = S_SUM;
      S_SUM: begin
        dk_nxt = 2'd0; st_nxt = S_DIV;
      end
      S_DIV: begin
        if (ddone) begin
          case (dk_r)
            2'd0: box_nxt[15:0]  = dpos ? dquo : 16'd0;
            2'd1: box_nxt[31:16] = dpos ? dquo : 16'd0;
            2'd2: box_nxt[47:32] = dpos ? dquo : 16'd0;
            default: box_nxt[63:48] = dpos ? dquo : 16'd0;
          endcase
          if (dk_r == 2'd3) begin
            idx_nxt = '0; st_nxt = S_SCAN;
          end else begin
            dk_nxt = dk_r + 2'd1;
          end
        end
        // start the divider once the coordinate index is settled
        if (!ddone && !drun) dgo = 1'b1;
      end
      S_SCAN: begin
        // address idx presented; compare next cycle
        if (idx_r >= cnt_r) begin
          if (cnt_r < CW'(MAX_BOXES)) begin
            we = 1'b1; waddr = cnt_r[AW-1:0];
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          st_nxt = cell_r.frame_end ? S_EMITR : S_IDLE;
          idx_nxt = '0;
        end else begin
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (ovl) begin
          if (cell_r.cell_score > rdata[79:64]) begin
            hit_nxt = idx_r; st_nxt = S_SHIFT;
            idx_nxt = idx_r + 1'b1;
          end else begin
            st_nxt = cell_r.frame_end ? S_EMITR : S_IDLE;
            idx_nxt = '0;
          end
        end else begin
          idx_nxt = idx_r + 1'b1; st_nxt = S_SCAN;
        end
      end
      S_SHIFT: begin
        // idx holds the entry being read, hit the slot it moves into
        if (idx_r >= cnt_r) begin
          we = 1'b1; waddr = AW'(cnt_r - 1'b1);
          st_nxt = cell_r.frame_end ? S_EMITR : S_IDLE;
          idx_nxt = '0;
        end else if (fe_r) begin
          we = 1'b1; waddr = hit_r[AW-1:0]; wdata = rdata;
          hit_nxt = idx_r; idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMITR: begin
        raddr = idx_r[AW-1:0];
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_strobe = 1'b1;
        out_data.list_overflow = ovf_r;
        if (cnt_r == '0) begin
          out_data.last_box = 1'b1;
        end else begin
          out_data.box_top    = rdata[15:0];
          out_data.box_left   = rdata[31:16];
          out_data.box_bottom = rdata[47:32];
          out_data.box_right  = rdata[63:48];
          out_data.box_score  = rdata[79:64];
          out_data.box_valid  = 1'b1;
          out_data.last_box   = (idx_r + 1'b1 == cnt_r);
        end
        if (cnt_r == '0 || idx_r + 1'b1 == cnt_r) begin
          cnt_nxt = '0; ovf_nxt = 1'b0; st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1; st_nxt = S_EMITR;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // read data valid in shift: toggles so each entry gets a read cycle
  always_ff @(posedge clk) begin
    if (!rst_n) fe_r <= 1'b0;
    else if (st_r == S_SHIFT && !(idx_r >= cnt_r)) fe_r <= !fe_r;
    else fe_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ovf_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
    end
    dk_r <= dk_nxt; box_r <= box_nxt; idx_r <= idx_nxt; hit_r <= hit_nxt;
    if (accept) cell_r <= in_data;
  end

  // ---- decode datapath, registered in the TRIG, MUL and SUM states
  logic [8:0] colc, rowc;
  assign colc = (cell_r.cell_col > 9'(GRID_MAX - 1)) ? 9'(GRID_MAX - 1) : cell_r.cell_col;
  assign rowc = (cell_r.cell_row > 9'(GRID_MAX - 1)) ? 9'(GRID_MAX - 1) : cell_r.cell_row;
  always_ff @(posedge clk) begin
    if (st_r == S_TRIG) begin
      s_r <= cell_r.rotation[15] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
      c_r <= $signed({1'b0, cv});
    end
    if (st_r == S_MUL) begin
      m_r[0] <= 48'(c_r * cell_r.dist_right);
      m_r[1] <= 48'(s_r * cell_r.dist_bottom);
      m_r[2] <= 48'(s_r * cell_r.dist_right);
      m_r[3] <= 48'(c_r * cell_r.dist_bottom);
    end
    if (st_r == S_SUM) begin
      rr_r <= ($signed(48'(colc)) <<< 20) + m_r[0] + m_r[1];
      bb_r <= ($signed(48'(rowc)) <<< 20) - m_r[2] + m_r[3];
      ll_r <= ($signed(48'(colc)) <<< 20) + m_r[0] + m_r[1] -
              ((48'(cell_r.dist_right) + 48'(cell_r.dist_left)) <<< 14);
      tt_r <= ($signed(48'(rowc)) <<< 20) - m_r[2] + m_r[3] -
              ((48'(cell_r.dist_top) + 48'(cell_r.dist_bottom)) <<< 14);
    end
  end

  // ---- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BOXES)) else $error("kept count past list depth");
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result word while idle");
  a_last_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last_box) |=> (cnt_r == '0 && !ovf_r))
    else $error("list not cleared after frame");
endmodule
